// ===== rtl/core/cmpr_pkg.sv =====
// Shared types, constants and helper functions for the cursor mask converter.
// Used by the controller, the datapath and the top level; depends on nothing.
package cmpr_pkg;

   // Image size limits and derived widths
   localparam int unsigned MAX_WIDTH   = 64;
   localparam int unsigned MAX_HEIGHT  = 64;
   localparam int unsigned MAX_DIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int unsigned COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int unsigned DIM_W       = $clog2(MAX_DIM + 1);

   // Register file
   localparam int unsigned CFG_W   = 7;
   localparam int unsigned INDEX_W = 2;
   localparam logic [INDEX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [INDEX_W-1:0] REG_MONO   = 2'd2;
   localparam logic [CFG_W-1:0]   RESET_WIDTH  = 7'd32;
   localparam logic [CFG_W-1:0]   RESET_HEIGHT = 7'd32;

   // Operation codes carried in the request tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Pixel constants
   localparam logic [31:0] PIX_BLACK  = 32'hFF00_0000;
   localparam logic [31:0] PIX_WHITE  = 32'hFFFF_FFFF;
   localparam logic [31:0] PIX_CLEAR  = 32'h0000_0000;
   localparam logic [31:0] MASK_WHITE = 32'h00FF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_DOWN,
      ST_FETCH_LEFT,
      ST_FETCH_RIGHT,
      ST_MULT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      NB_UP,
      NB_DOWN,
      NB_LEFT,
      NB_RIGHT
   } nbr_type;

   typedef struct packed {
      logic    load_pixel;
      logic    fetch_center;
      logic    fetch_nbr;
      nbr_type fetch_sel;
      logic    latch_center;
      logic    latch_nbr;
      nbr_type latch_sel;
      logic    mult_en;
      logic    set_error;
      logic    emit;
   } cmd_type;

   typedef struct packed {
      logic read_ok;
      logic rsp_free;
   } status_type;

   // Clamp a size register to 1..maxv
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input int unsigned maxv);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (32'(v) > maxv) begin
         return DIM_W'(maxv);
      end
      return DIM_W'(v);
   endfunction

   // floor(p / 255) for any product of two bytes
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] s;
      s = {1'b0, p} + 17'(p[15:8]) + 17'd1;
      return s[15:8];
   endfunction

endpackage

// ===== rtl/core/cmpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module cmpr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cmpr_ctrl.sv =====
// Controller state machine: sequences loads and the pixel readout.
// Depends on cmpr_pkg; drives the datapath through cmd_type only.
module cmpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tuser,
   input  cmpr_pkg::status_type status,
   output logic                 req_tready,
   output cmpr_pkg::cmd_type    cmd
);
   import cmpr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_tuser == OP_READ)) begin
               state_in = status.read_ok ? ST_FETCH_DOWN : ST_EMIT;
            end
         end
         ST_FETCH_DOWN:  state_in = ST_FETCH_LEFT;
         ST_FETCH_LEFT:  state_in = ST_FETCH_RIGHT;
         ST_FETCH_RIGHT: state_in = ST_MULT;
         ST_MULT:        state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready       = 1'b0;
      cmd              = '0;
      cmd.fetch_sel    = NB_UP;
      cmd.latch_sel    = NB_UP;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_LOAD) begin
                  cmd.load_pixel = 1'b1;
               end else if (status.read_ok) begin
                  cmd.fetch_center = 1'b1;
                  cmd.fetch_nbr    = 1'b1;
                  cmd.fetch_sel    = NB_UP;
               end else begin
                  cmd.set_error = 1'b1;
               end
            end
         end
         ST_FETCH_DOWN: begin
            cmd.latch_center = 1'b1;
            cmd.latch_nbr    = 1'b1;
            cmd.latch_sel    = NB_UP;
            cmd.fetch_nbr    = 1'b1;
            cmd.fetch_sel    = NB_DOWN;
         end
         ST_FETCH_LEFT: begin
            cmd.latch_nbr = 1'b1;
            cmd.latch_sel = NB_DOWN;
            cmd.fetch_nbr = 1'b1;
            cmd.fetch_sel = NB_LEFT;
         end
         ST_FETCH_RIGHT: begin
            cmd.latch_nbr = 1'b1;
            cmd.latch_sel = NB_LEFT;
            cmd.fetch_nbr = 1'b1;
            cmd.fetch_sel = NB_RIGHT;
         end
         ST_MULT: begin
            cmd.mult_en = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
            cmd.emit = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/cmpr_datapath.sv =====
// Datapath: size registers, pixel stores, counters, outline test, premultiply
// and the result register. Depends on cmpr_pkg and cmpr_ram.
module cmpr_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [63:0]                     req_tdata,
   input  logic                            csr_write,
   input  logic [cmpr_pkg::INDEX_W-1:0]    csr_index,
   input  logic [cmpr_pkg::CFG_W-1:0]      csr_data,
   input  cmpr_pkg::cmd_type               cmd,
   output cmpr_pkg::status_type            status,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [31:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser
);
   import cmpr_pkg::*;

   // configuration
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             mono_ff, mono_in;

   // image state
   logic [COUNT_W-1:0] load_count_ff, load_count_in;
   logic [COUNT_W-1:0] read_count_ff, read_count_in;
   logic [DIM_W-1:0]   read_x_ff, read_x_in;
   logic [DIM_W-1:0]   read_y_ff, read_y_in;
   logic               alpha_seen_ff, alpha_seen_in;
   logic               reverse_seen_ff, reverse_seen_in;

   // readout working registers
   logic [31:0] center_color_ff, center_color_in;
   logic        center_mask_ff, center_mask_in;
   logic        up_ff, up_in;
   logic        down_ff, down_in;
   logic        left_ff, left_in;
   logic [15:0] prod_b_ff, prod_b_in;
   logic [15:0] prod_g_ff, prod_g_in;
   logic [15:0] prod_r_ff, prod_r_in;
   logic [7:0]  alpha_ff, alpha_in;
   logic        err_ff, err_in;

   // result register
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0] rsp_tdata_ff, rsp_tdata_in;
   logic        rsp_tlast_ff, rsp_tlast_in;
   logic        rsp_tuser_ff, rsp_tuser_in;

   logic [DIM_W-1:0]   used_w, used_h;
   logic [COUNT_W-1:0] total;
   logic [COUNT_W:0]   read_next;
   logic               is_last;
   logic               load_ok;
   logic               load_we;
   logic [31:0]        load_mask;
   logic [31:0]        load_color;
   logic               load_mask_bit;
   logic               load_black;
   logic [DIM_W-1:0]   x_next, y_next;
   logic [ADDR_W-1:0]  idx, w_addr, nbr_addr;
   logic               nbr_ok_latch, right_ok;
   logic [32:0]        center_rd;
   logic [0:0]         black_rd;
   logic               restart;
   logic               cfg_hit;
   logic [31:0]        table_pix, pix_sel;
   logic               edge_hit;
   logic [7:0]         pix_a;

   assign used_w    = clamp_dim(width_ff, MAX_WIDTH);
   assign used_h    = clamp_dim(height_ff, MAX_HEIGHT);
   assign total     = COUNT_W'(used_w * used_h);
   assign read_next = {1'b0, read_count_ff} + (COUNT_W+1)'(1);
   assign is_last   = read_next >= {1'b0, total};

   assign load_ok        = (read_count_ff == '0) && (load_count_ff < total);
   assign status.read_ok = (load_count_ff >= total) && (read_count_ff < total);
   assign status.rsp_free = !rsp_tvalid_ff || rsp_tready;

   assign load_mask     = req_tdata[31:0];
   assign load_color    = req_tdata[63:32];
   assign load_mask_bit = (load_mask == MASK_WHITE);
   // neighbor is black under the AND/XOR table
   assign load_black    = load_mask_bit ? (load_color != '0) : (load_color == '0);
   assign load_we       = cmd.load_pixel && load_ok;

   assign x_next = read_x_ff + DIM_W'(1);
   assign y_next = read_y_ff + DIM_W'(1);
   assign idx    = read_count_ff[ADDR_W-1:0];
   assign w_addr = ADDR_W'(used_w);

   always_comb begin
      unique case (cmd.fetch_sel)
         NB_UP:    nbr_addr = idx - w_addr;
         NB_DOWN:  nbr_addr = idx + w_addr;
         NB_LEFT:  nbr_addr = idx - ADDR_W'(1);
         NB_RIGHT: nbr_addr = idx + ADDR_W'(1);
         default:  nbr_addr = idx;
      endcase
   end

   always_comb begin
      unique case (cmd.latch_sel)
         NB_UP:    nbr_ok_latch = (read_y_ff != '0);
         NB_DOWN:  nbr_ok_latch = (y_next < used_h);
         NB_LEFT:  nbr_ok_latch = (read_x_ff != '0);
         NB_RIGHT: nbr_ok_latch = (x_next < used_w);
         default:  nbr_ok_latch = 1'b0;
      endcase
   end
   assign right_ok = (x_next < used_w);

   cmpr_ram #(
      .WIDTH (33),
      .DEPTH (STORE_DEPTH)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (load_count_ff[ADDR_W-1:0]),
      .wr_data ({load_mask_bit, load_color}),
      .rd_en   (cmd.fetch_center),
      .rd_addr (idx),
      .rd_data (center_rd)
   );

   cmpr_ram #(
      .WIDTH (1),
      .DEPTH (STORE_DEPTH)
   ) u_black_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (load_count_ff[ADDR_W-1:0]),
      .wr_data (load_black),
      .rd_en   (cmd.fetch_nbr),
      .rd_addr (nbr_addr),
      .rd_data (black_rd)
   );

   // pixel selection: alpha image passes through, else AND/XOR plus outline
   always_comb begin
      if (center_mask_ff) begin
         table_pix = (center_color_ff != '0) ? PIX_BLACK : PIX_CLEAR;
      end else begin
         table_pix = center_color_ff ^ PIX_BLACK;
      end
      edge_hit = up_ff || down_ff || left_ff || (black_rd[0] && right_ok);
      if (alpha_seen_ff && !mono_ff) begin
         pix_sel = center_color_ff;
      end else if (reverse_seen_ff && (table_pix == PIX_CLEAR) && edge_hit) begin
         pix_sel = PIX_WHITE;
      end else begin
         pix_sel = table_pix;
      end
   end
   assign pix_a = pix_sel[31:24];

   assign cfg_hit = csr_write &&
                    ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT) ||
                     (csr_index == REG_MONO));
   assign restart = cfg_hit || (cmd.emit && !err_ff && is_last);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mono_in   = mono_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = csr_data;
            REG_HEIGHT: height_in = csr_data;
            REG_MONO:   mono_in   = csr_data[0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      load_count_in   = load_count_ff;
      read_count_in   = read_count_ff;
      read_x_in       = read_x_ff;
      read_y_in       = read_y_ff;
      alpha_seen_in   = alpha_seen_ff;
      reverse_seen_in = reverse_seen_ff;
      if (restart) begin
         load_count_in   = '0;
         read_count_in   = '0;
         read_x_in       = '0;
         read_y_in       = '0;
         alpha_seen_in   = 1'b0;
         reverse_seen_in = 1'b0;
      end else if (load_we) begin
         load_count_in = load_count_ff + COUNT_W'(1);
         if (!mono_ff && (load_color[31:24] != '0)) begin
            alpha_seen_in = 1'b1;
         end
         if (load_mask_bit && (load_color != '0)) begin
            reverse_seen_in = 1'b1;
         end
      end else if (cmd.emit && !err_ff) begin
         read_count_in = read_next[COUNT_W-1:0];
         if (x_next == used_w) begin
            read_x_in = '0;
            read_y_in = y_next;
         end else begin
            read_x_in = x_next;
         end
      end
   end

   always_comb begin
      center_color_in = center_color_ff;
      center_mask_in  = center_mask_ff;
      up_in           = up_ff;
      down_in         = down_ff;
      left_in         = left_ff;
      prod_b_in       = prod_b_ff;
      prod_g_in       = prod_g_ff;
      prod_r_in       = prod_r_ff;
      alpha_in        = alpha_ff;
      err_in          = err_ff;
      if (cmd.latch_center) begin
         center_color_in = center_rd[31:0];
         center_mask_in  = center_rd[32];
      end
      if (cmd.latch_nbr) begin
         unique case (cmd.latch_sel)
            NB_UP:    up_in   = black_rd[0] && nbr_ok_latch;
            NB_DOWN:  down_in = black_rd[0] && nbr_ok_latch;
            NB_LEFT:  left_in = black_rd[0] && nbr_ok_latch;
            NB_RIGHT: left_in = left_ff;
            default:  left_in = left_ff;
         endcase
      end
      if (cmd.mult_en) begin
         prod_b_in = 16'(pix_sel[7:0] * pix_a);
         prod_g_in = 16'(pix_sel[15:8] * pix_a);
         prod_r_in = 16'(pix_sel[23:16] * pix_a);
         alpha_in  = pix_a;
         err_in    = 1'b0;
      end
      if (cmd.set_error) begin
         err_in = 1'b1;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tuser_in  = err_ff;
         rsp_tlast_in  = !err_ff && is_last;
         if (err_ff) begin
            rsp_tdata_in = PIX_CLEAR;
         end else begin
            rsp_tdata_in = {alpha_ff, div255(prod_r_ff), div255(prod_g_ff),
                            div255(prod_b_ff)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= RESET_WIDTH;
         height_ff       <= RESET_HEIGHT;
         mono_ff         <= 1'b0;
         load_count_ff   <= '0;
         read_count_ff   <= '0;
         read_x_ff       <= '0;
         read_y_ff       <= '0;
         alpha_seen_ff   <= 1'b0;
         reverse_seen_ff <= 1'b0;
         err_ff          <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         width_ff        <= width_in;
         height_ff       <= height_in;
         mono_ff         <= mono_in;
         load_count_ff   <= load_count_in;
         read_count_ff   <= read_count_in;
         read_x_ff       <= read_x_in;
         read_y_ff       <= read_y_in;
         alpha_seen_ff   <= alpha_seen_in;
         reverse_seen_ff <= reverse_seen_in;
         err_ff          <= err_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      center_color_ff <= center_color_in;
      center_mask_ff  <= center_mask_in;
      up_ff           <= up_in;
      down_ff         <= down_in;
      left_ff         <= left_in;
      prod_b_ff       <= prod_b_in;
      prod_g_ff       <= prod_g_in;
      prod_r_ff       <= prod_r_in;
      alpha_ff        <= alpha_in;
      rsp_tdata_ff    <= rsp_tdata_in;
      rsp_tlast_ff    <= rsp_tlast_in;
      rsp_tuser_ff    <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== rtl/core/cursor_mask_to_premultiplied_rgba.sv =====
// Top level of the AND/XOR cursor mask to premultiplied RGBA converter.
// Depends on cmpr_pkg, cmpr_ctrl and cmpr_datapath.
//
// Load transactions (tuser 0) bring one cursor pixel each in raster order;
// once width*height pixels are in, read transactions (tuser 1) return the
// converted pixels in raster order, with tlast on the final pixel, after
// which the block is ready for a new image. An accepted read fetches the
// four neighbor flags for the outline test one after another through the
// single read port of the neighbor-flag memory, then multiplies, and is
// divided by 255 as it is loaded into the result register once that register
// is free. A read before the image is complete returns a zero pixel with
// tuser set. Loads sent during a readout or beyond the image are dropped. The
// pixel memories have no reset and need no clearing pass; only loaded entries
// are read. A write to the width, height or mono register restarts the image.
// Write registers only while no transaction is in flight.
module cursor_mask_to_premultiplied_rgba (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] mask_word, [63:32] color_word
   input  logic        req_tuser,   // [0] operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pixel_out
   output logic        rsp_tlast,   // last_pixel
   output logic        rsp_tuser,   // [0] read_error
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import cmpr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // registers always take a write at once
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   cmpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   cmpr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // a result is never written over one still waiting to be taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // an accepted read holds off the next request
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_READ)) |=> !req_tready)
      else $error("request accepted during readout");

   // an error result never closes an image
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tlast)
      else $error("error result flagged as last pixel");

   // a write to the width, height or mono register restarts the image
   assert property (@(posedge clock) disable iff (reset)
      (csr_write && ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT) ||
                     (csr_index == REG_MONO))) |=> !status.read_ok)
      else $error("image not restarted by register write");

endmodule

// ===== verif/cmpr_checker.sv =====
`timescale 1ns / 1ps
// Checker for the cursor mask converter: watches the request, result and register channels.
// It predicts every result from its own pixel stores and compares in order.
// Depends on cmpr_pkg for the register indexes, operation codes and pixel constants.
module cmpr_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [63:0]       req_tdata,   // [31:0] mask_word, [63:32] color_word
   input  logic              req_tuser,   // [0] operation
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [31:0]       rsp_tdata,   // [31:0] pixel_out
   input  logic              rsp_tlast,   // last_pixel
   input  logic              rsp_tuser,   // [0] read_error
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data,
   output int unsigned       mismatch_count,
   output int unsigned       outstanding,
   output int unsigned       results_seen
);
   import cmpr_pkg::*;

   typedef struct packed {
      logic [31:0] pixel;
      logic        last;
      logic        err;
   } pixel_result_type;

   pixel_result_type pixel_q[$];

   logic [31:0] color_mem [STORE_DEPTH];
   logic        mask_mem  [STORE_DEPTH];
   logic [6:0]  width_reg;
   logic [6:0]  height_reg;
   logic        mono_reg;
   int unsigned load_cnt;
   int unsigned read_cnt;
   logic        alpha_flag;
   logic        reverse_flag;
   int unsigned fail_cnt;
   int unsigned result_cnt;

   initial begin
      fail_cnt   = 0;
      result_cnt = 0;
   end

   function automatic int unsigned clamp_size(input logic [6:0] v, input int unsigned maxv);
      if (v == '0) begin
         return 1;
      end
      if (32'(v) > maxv) begin
         return maxv;
      end
      return 32'(v);
   endfunction

   function automatic logic [31:0] and_xor_pixel(input int unsigned idx);
      if (mask_mem[idx]) begin
         return (color_mem[idx] != '0) ? PIX_BLACK : PIX_CLEAR;
      end
      return color_mem[idx] ^ PIX_BLACK;
   endfunction

   function automatic logic [31:0] premultiply_pixel(input logic [31:0] p);
      int unsigned a, r, g, b;
      a = p[31:24];
      b = p[7:0];
      g = p[15:8];
      r = p[23:16];
      b = (b * a) / 255;
      g = (g * a) / 255;
      r = (r * a) / 255;
      return {8'(a), 8'(r), 8'(g), 8'(b)};
   endfunction

   // Alpha images pass straight through; otherwise AND/XOR table plus outline.
   function automatic logic [31:0] predict_pixel(input int unsigned idx, input int unsigned w,
                                                 input int unsigned h);
      logic [31:0] p;
      int unsigned x, y;
      logic        near_black;
      if (alpha_flag && !mono_reg) begin
         p = color_mem[idx];
      end else begin
         p = and_xor_pixel(idx);
         if (reverse_flag && p == PIX_CLEAR) begin
            x = idx % w;
            y = idx / w;
            near_black = 1'b0;
            if (y > 0 && and_xor_pixel(idx - w) == PIX_BLACK) near_black = 1'b1;
            if (y + 1 < h && and_xor_pixel(idx + w) == PIX_BLACK) near_black = 1'b1;
            if (x > 0 && and_xor_pixel(idx - 1) == PIX_BLACK) near_black = 1'b1;
            if (x + 1 < w && and_xor_pixel(idx + 1) == PIX_BLACK) near_black = 1'b1;
            if (near_black) p = PIX_WHITE;
         end
      end
      return premultiply_pixel(p);
   endfunction

   task automatic restart_image();
      load_cnt     = 0;
      read_cnt     = 0;
      alpha_flag   = 1'b0;
      reverse_flag = 1'b0;
   endtask

   task automatic note_mismatch(input string what, input pixel_result_type want,
                                input pixel_result_type got);
      fail_cnt++;
      if (fail_cnt <= 10) begin
         $display("[%0t] %s: expected pixel %h last %b error %b, got pixel %h last %b error %b",
                  $realtime, what, want.pixel, want.last, want.err,
                  got.pixel, got.last, got.err);
      end
   endtask

   task automatic predict_request(input logic op, input logic [31:0] m, input logic [31:0] c);
      int unsigned      w, h, total;
      pixel_result_type r;
      w     = clamp_size(width_reg, MAX_WIDTH);
      h     = clamp_size(height_reg, MAX_HEIGHT);
      total = w * h;
      if (op == OP_LOAD) begin
         // drop loads during a readout or past the end of the image
         if (read_cnt == 0 && load_cnt < total) begin
            color_mem[load_cnt] = c;
            mask_mem[load_cnt]  = (m == MASK_WHITE);
            if (!mono_reg && c[31:24] != '0) alpha_flag = 1'b1;
            if (m == MASK_WHITE && c != '0) reverse_flag = 1'b1;
            load_cnt++;
         end
      end else if (load_cnt < total || read_cnt >= total) begin
         r = '{PIX_CLEAR, 1'b0, 1'b1};
         pixel_q.push_back(r);
      end else begin
         r.pixel = predict_pixel(read_cnt, w, h);
         r.err   = 1'b0;
         r.last  = (read_cnt + 1 >= total);
         if (r.last) begin
            restart_image();
         end else begin
            read_cnt++;
         end
         pixel_q.push_back(r);
      end
   endtask

   always @(posedge clock) begin : monitor
      pixel_result_type got, want;
      if (reset) begin
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         mono_reg   = 1'b0;
         restart_image();
         pixel_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_cnt++;
            got = '{rsp_tdata, rsp_tlast, rsp_tuser};
            if (pixel_q.size() == 0) begin
               note_mismatch("result with nothing predicted", '0, got);
            end else begin
               want = pixel_q.pop_front();
               if (got.pixel !== want.pixel || got.last !== want.last || got.err !== want.err)
                  note_mismatch("result mismatch", want, got);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH: begin
                  width_reg = csr_data;
                  restart_image();
               end
               REG_HEIGHT: begin
                  height_reg = csr_data;
                  restart_image();
               end
               REG_MONO: begin
                  mono_reg = csr_data[0];
                  restart_image();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata[31:0], req_tdata[63:32]);
      end
      mismatch_count <= fail_cnt;
      outstanding    <= pixel_q.size();
      results_seen   <= result_cnt;
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the cursor mask converter testbench: clock, reset, stimulus and verdict.
// Instantiates cursor_mask_to_premultiplied_rgba and cmpr_checker; uses cmpr_pkg.
module tb_top;
   import cmpr_pkg::*;

   localparam int unsigned ITEM_GOAL      = 1700;
   // let any read still in flight settle before register writes
   localparam int unsigned DRAIN_HOLD     = 16;
   // cycles with no transaction on any channel before the run is called hung
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   // index past the register list: the block must ignore it
   localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = OP_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = REG_WIDTH;
   logic [6:0]  csr_data   = '0;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned results_seen;

   int unsigned send_idle_pct = 16;
   int unsigned recv_idle_pct = 64;
   int unsigned item_count    = 0;
   int unsigned image_count   = 0;
   int unsigned cfg_count     = 0;
   int unsigned idle_cycles   = 0;
   bit          need_cfg      = 1'b0;

   // settings as last written, to size the stimulus
   logic [6:0]  cur_width  = RESET_WIDTH;
   logic [6:0]  cur_height = RESET_HEIGHT;
   logic        cur_mono   = 1'b0;

   cursor_mask_to_premultiplied_rgba u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cmpr_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .results_seen   (results_seen)
   );

   always #6 clock = ~clock;

   // Result side: stall at random, with the rate set by the current pressure phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: count cycles in which no channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no transaction for %0d cycles, %0d results still due",
                  $realtime, WATCHDOG_LIMIT, outstanding);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int unsigned eff_dim(input logic [6:0] v, input int unsigned maxv);
      if (v == '0) return 1;
      if (32'(v) > maxv) return maxv;
      return 32'(v);
   endfunction

   // Send one request transaction; leave tvalid high so back-to-back items stream.
   task automatic send_request(input logic op, input logic [31:0] m, input logic [31:0] c,
                               input bit counted);
      // pressure phases: slow receiver, then slow sender, then neither idles
      if (item_count < ITEM_GOAL / 3) begin
         send_idle_pct = 16;
         recv_idle_pct <= 64;
      end else if (item_count < 2 * ITEM_GOAL / 3) begin
         send_idle_pct = 64;
         recv_idle_pct <= 16;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct <= 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {c, m};
      do @(posedge clock); while (!req_tready);
      if (counted) item_count++;
   endtask

   // Write one register; the caller drops csr_valid after its last write.
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_WIDTH:  cur_width  = value;
         REG_HEIGHT: cur_height = value;
         REG_MONO:   cur_mono   = value[0];
         default: ;
      endcase
      cfg_count++;
   endtask

   // Stop requests, wait for every predicted result, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_HOLD) @(posedge clock);
   endtask

   // One random image: optional new settings, loads with noise, then the readout.
   task automatic run_image();
      int unsigned w, h, total, stop_at, i, k;
      logic [6:0]  wv, hv;
      logic        alpha_free, no_reverse, abort_load, abort_read;
      logic [31:0] m, c;
      if (need_cfg || $urandom_range(0, 99) < 60) begin
         drain();
         // mostly tiny images; a few hit the size limits and the clamps
         k = $urandom_range(0, 99);
         if (k < 70) begin
            wv = 7'($urandom_range(1, 6));
            hv = 7'($urandom_range(1, 6));
         end else if (k < 82) begin
            wv = 7'($urandom_range(7, 16));
            hv = 7'($urandom_range(1, 4));
         end else if (k < 92) begin
            wv = 7'($urandom_range(1, 4));
            hv = 7'($urandom_range(7, 16));
         end else if (k < 96) begin
            wv = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(63, 127));
            hv = 7'($urandom_range(1, 2));
         end else begin
            wv = 7'($urandom_range(1, 2));
            hv = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(63, 127));
         end
         write_reg(REG_WIDTH, wv);
         write_reg(REG_HEIGHT, hv);
         // upper data bits of the mode register are don't-care
         if (need_cfg || $urandom_range(0, 1) == 1)
            write_reg(REG_MONO, {6'($urandom), 1'($urandom)});
         if ($urandom_range(0, 99) < 10) write_reg(REG_UNUSED, 7'($urandom));
         csr_valid <= 1'b0;
         need_cfg = 1'b0;
      end

      w          = eff_dim(cur_width, MAX_WIDTH);
      h          = eff_dim(cur_height, MAX_HEIGHT);
      total      = w * h;
      alpha_free = ($urandom_range(0, 99) < 60);
      no_reverse = ($urandom_range(0, 99) < 25);
      abort_load = ($urandom_range(0, 99) < 6);
      abort_read = !abort_load && ($urandom_range(0, 99) < 4);
      stop_at    = $urandom_range(0, total - 1);

      for (i = 0; i < total; i++) begin
         if (abort_load && i == stop_at) break;
         // early read: error result, no state change
         if ($urandom_range(0, 99) < 3) send_request(OP_READ, $urandom, $urandom, 1'b1);
         k = $urandom_range(0, 99);
         if (k < 40) m = MASK_WHITE;
         else if (k < 70) m = '0;
         else if (k < 75) m = 32'hFFFF_FFFF;
         else m = $urandom;
         k = $urandom_range(0, 99);
         if (k < 35) c = '0;
         else if (k < 45) c = 32'h00FF_FFFF;
         else if (k < 50) c = 32'hFFFF_FFFF;
         else c = $urandom;
         // keep the alpha scan clear so color cursors also take the table path
         if (alpha_free && !cur_mono) c[31:24] = '0;
         if (no_reverse && m == MASK_WHITE) c = '0;
         send_request(OP_LOAD, m, c, 1'b1);
      end
      if (abort_load) begin
         drain();
         need_cfg = 1'b1;
         return;
      end
      // load past the end of the image: dropped
      if ($urandom_range(0, 99) < 10) send_request(OP_LOAD, $urandom, $urandom, 1'b0);

      for (i = 0; i < total; i++) begin
         if (abort_read && i == stop_at) begin
            drain();
            need_cfg = 1'b1;
            return;
         end
         // load during the readout: dropped
         if ($urandom_range(0, 99) < 3) send_request(OP_LOAD, $urandom, $urandom, 1'b0);
         send_request(OP_READ, $urandom, $urandom, 1'b1);
      end
      image_count++;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // 2x2 monochrome image through the AND/XOR table
      write_reg(REG_WIDTH, 7'd2);
      write_reg(REG_HEIGHT, 7'd2);
      write_reg(REG_MONO, 7'd1);
      csr_valid <= 1'b0;
      send_request(OP_READ, '0, '0, 1'b1);                      // read with nothing loaded
      send_request(OP_LOAD, MASK_WHITE, 32'hFFFF_FFFF, 1'b1);   // reverse pixel: black
      send_request(OP_LOAD, MASK_WHITE, '0, 1'b1);              // transparent next to black
      send_request(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // read of a partial image
      send_request(OP_LOAD, '0, 32'h1234_5678, 1'b1);           // mask clear: XOR
      send_request(OP_LOAD, 32'hFFFF_FFFF, '0, 1'b1);           // not the white mask word
      send_request(OP_LOAD, MASK_WHITE, 32'hFFFF_FFFF, 1'b0);   // past the end: dropped
      send_request(OP_READ, '0, '0, 1'b1);
      send_request(OP_LOAD, MASK_WHITE, 32'h0000_0001, 1'b0);   // during readout: dropped
      repeat (3) send_request(OP_READ, '0, '0, 1'b1);           // last pixel restarts
      send_request(OP_READ, '0, '0, 1'b1);                      // read after the restart
      drain();

      // 1x1 color cursor: one image with alpha, one without
      write_reg(REG_WIDTH, 7'd1);
      write_reg(REG_HEIGHT, 7'd1);
      write_reg(REG_MONO, 7'd0);
      csr_valid <= 1'b0;
      send_request(OP_LOAD, 32'hFFFF_FFFF, 32'h80FF_7F01, 1'b1);
      send_request(OP_READ, '0, '0, 1'b1);
      send_request(OP_LOAD, '0, 32'h00FF_FFFF, 1'b1);
      send_request(OP_READ, '0, '0, 1'b1);
      drain();

      // 1x2: a write to the unused index mid-image must not restart it
      write_reg(REG_HEIGHT, 7'd2);
      csr_valid <= 1'b0;
      send_request(OP_LOAD, '0, 32'hFF00_00FF, 1'b1);
      drain();
      write_reg(REG_UNUSED, 7'h7F);
      csr_valid <= 1'b0;
      send_request(OP_LOAD, MASK_WHITE, '0, 1'b1);
      repeat (2) send_request(OP_READ, '0, '0, 1'b1);

      while (item_count < ITEM_GOAL) run_image();

      drain();
      $display("Sent %0d requests: %0d complete random images, %0d register writes",
               item_count, image_count, cfg_count);
      $display("Checked %0d results across monochrome, color and alpha cursors",
               results_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
